@@ rtl/tlr_pkg.sv @@
// package for the thick line rasterizer: defaults, register indexes, fsm codes
// and the command / status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlr_pkg;

  // parameter defaults
  localparam int COORD_BITS_DEF    = 12;
  localparam int MAX_THICKNESS_DEF = 7;
  localparam int COLOR_BITS_DEF    = 32;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int FRAME_BITS    = 12;
  localparam int Y_OFF_BITS    = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ROW_BIAS     = 2'd2
  } cfg_idx_t;

  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [Y_OFF_BITS-1:0] ROW_BIAS_RST     = 10'd0;

  // input item modes
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // brush geometry: half size is at most 3, offsets held as 3-bit signed
  localparam int HALF_BITS = 2;
  localparam int OFS_BITS  = 3;
  localparam int THICK_BITS = 3;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC_D = 4'b0010,
    S_CALC_E = 4'b0100,
    S_EMIT   = 4'b1000
  } tlr_state_t;

  typedef struct packed {
    logic load;    // start item accepted: load endpoints, colour, brush
    logic step;    // advance item accepted on an active line: one bresenham step
    logic calc_d;  // form distances and step directions
    logic calc_e;  // form the initial error term
    logic emit;    // put the next brush pixel into the output register
  } tlr_cmd_t;

  typedef struct packed {
    logic line_active;
    logic brush_last;
    logic out_free;
  } tlr_status_t;

endpackage

`default_nettype wire

@@ rtl/tlr_channel_if.sv @@
// valid/ready channel interfaces for the thick line rasterizer:
// tlr_in_if carries line items, tlr_out_if carries brush pixels
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface tlr_in_if #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [2:0]                   thickness;
  logic [COLOR_BITS-1:0]        line_color;

  modport source (
    output valid, mode, x_start, y_start, x_end, y_end, thickness, line_color,
    input  ready
  );
  modport sink (
    input  valid, mode, x_start, y_start, x_end, y_end, thickness, line_color,
    output ready
  );
endinterface

interface tlr_out_if #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic [COLOR_BITS-1:0]      pixel_color;
  logic                       write_enable;
  logic                       point_last;
  logic                       line_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, write_enable, point_last, line_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, write_enable, point_last, line_done,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/thick_line_rasterizer.sv @@
// thick line rasterizer: bresenham stepping with a square brush, one pixel a cycle.
//
// in_if carries line items (valid/ready). a start item (mode 0) loads both
// endpoints, adds the row bias register to their y values, latches thickness and
// colour and scans the brush around the first point; an advance item (mode 1)
// takes one bresenham step and scans the brush around the new point. an advance
// with no line in progress is taken and produces nothing.
// out_if carries one transaction per brush pixel, x outer and y inner, with
// write_enable set for pixels inside the frame, point_last on the last pixel
// of each point and line_done on the last pixel of the final endpoint.
// a start item forms the distances, then the error term, then scans its brush; an
// advance item takes one step and scans. a brush is (2h+1)^2 pixels, up to 49, with
// h = thickness/2; the brush scan is one pixel per cycle through the single output
// register, and another item is taken only once the brush has fully passed to it.
// a stalled receiver holds the output register and freezes the scan.
// reset (synchronous, rst_n low) drops any line in progress, empties the output
// register and restores frame 640x480 with a zero row bias. cfg writes are
// registered and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module thick_line_rasterizer #(
  parameter int COORD_BITS    = tlr_pkg::COORD_BITS_DEF,
  parameter int MAX_THICKNESS = tlr_pkg::MAX_THICKNESS_DEF,
  parameter int COLOR_BITS    = tlr_pkg::COLOR_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  tlr_in_if.sink                           in_if,
  tlr_out_if.source                        out_if,
  input  wire                              cfg_we,
  input  wire [tlr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [tlr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tlr_pkg::*;

  tlr_cmd_t    cmd;
  tlr_status_t status;

  tlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlr_datapath #(
    .COORD_BITS    (COORD_BITS),
    .MAX_THICKNESS (MAX_THICKNESS),
    .COLOR_BITS    (COLOR_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .x_start    (in_if.x_start),
    .y_start    (in_if.y_start),
    .x_end      (in_if.x_end),
    .y_end      (in_if.y_end),
    .thickness  (in_if.thickness),
    .line_color (in_if.line_color),
    .cmd        (cmd),
    .status     (status),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

@@ rtl/tlr_ctrl.sv @@
// controller state machine of the thick line rasterizer
// depends on tlr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_mode,
  output logic                in_ready,
  input  tlr_pkg::tlr_status_t status,
  output tlr_pkg::tlr_cmd_t    cmd
);
  import tlr_pkg::*;

  tlr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_START) begin
            cmd.load  = 1'b1;
            state_nxt = S_CALC_D;
          end else if (status.line_active) begin
            cmd.step  = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_CALC_D: begin
        cmd.calc_d = 1'b1;
        state_nxt  = S_CALC_E;
      end
      S_CALC_E: begin
        cmd.calc_e = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.brush_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tlr_datapath.sv @@
// datapath of the thick line rasterizer: configuration registers, bresenham
// state, brush scan counters and the output register
// depends on tlr_pkg and tlr_out_if
`timescale 1ns / 1ps
`default_nettype none

module tlr_datapath #(
  parameter int COORD_BITS    = tlr_pkg::COORD_BITS_DEF,
  parameter int MAX_THICKNESS = tlr_pkg::MAX_THICKNESS_DEF,
  parameter int COLOR_BITS    = tlr_pkg::COLOR_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [tlr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire [tlr_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  wire signed [COORD_BITS-1:0]          x_start,
  input  wire signed [COORD_BITS-1:0]          y_start,
  input  wire signed [COORD_BITS-1:0]          x_end,
  input  wire signed [COORD_BITS-1:0]          y_end,
  input  wire [tlr_pkg::THICK_BITS-1:0]        thickness,
  input  wire [COLOR_BITS-1:0]                 line_color,
  input  tlr_pkg::tlr_cmd_t                    cmd,
  output tlr_pkg::tlr_status_t                 status,
  tlr_out_if.source                            out_if
);
  import tlr_pkg::*;

  // internal coordinate width: endpoint plus y offset plus brush reach, with margin
  localparam int BASE_BITS = (COORD_BITS > Y_OFF_BITS + 1) ? COORD_BITS : Y_OFF_BITS + 1;
  localparam int IW = BASE_BITS + 2;
  localparam int DW = IW - 1;  // magnitude of an endpoint distance
  localparam int EW = IW + 1;  // error term
  localparam logic [THICK_BITS-1:0] THICK_MAX = THICK_BITS'(MAX_THICKNESS);

  // configuration
  logic [FRAME_BITS-1:0] frame_w_r, frame_h_r;
  logic [Y_OFF_BITS-1:0] y_off_r;

  // line state
  logic signed [IW-1:0]       cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [IW-1:0]       cur_x_nxt, cur_y_nxt;
  logic [DW-1:0]              dx_r, dy_r;
  logic                       neg_x_r, neg_y_r;
  logic signed [EW-1:0]       err_r, err_nxt;
  logic [HALF_BITS-1:0]       half_r, half_nxt;
  logic [COLOR_BITS-1:0]      color_r;
  logic                       line_active_r;
  logic signed [OFS_BITS-1:0] ofs_i_r, ofs_j_r;

  // output register
  logic                       out_valid_r;
  logic signed [COORD_BITS:0] out_x_r, out_y_r;
  logic [COLOR_BITS-1:0]      out_color_r;
  logic                       out_we_r, out_last_r, out_done_r;

  logic [THICK_BITS-1:0]      thick_sat;
  logic signed [IW:0]         diff_x, diff_y, rdiff_x, rdiff_y;
  logic signed [EW:0]         e2, ndy, pdx;
  logic                       move_x, move_y;
  logic signed [OFS_BITS-1:0] half_s, neg_half;
  logic signed [IW-1:0]       px, py;
  logic                       in_frame, done_w, brush_last;

  // start item values
  assign thick_sat = (thickness > THICK_MAX) ? THICK_MAX : thickness;
  assign half_nxt  = cmd.load ? thick_sat[THICK_BITS-1:1] : half_r;
  assign neg_half  = OFS_BITS'(0) - $signed({1'b0, half_nxt});
  assign half_s    = $signed({1'b0, half_r});

  // distances, both signs in parallel
  assign diff_x  = {tgt_x_r[IW-1], tgt_x_r} - {cur_x_r[IW-1], cur_x_r};
  assign diff_y  = {tgt_y_r[IW-1], tgt_y_r} - {cur_y_r[IW-1], cur_y_r};
  assign rdiff_x = {cur_x_r[IW-1], cur_x_r} - {tgt_x_r[IW-1], tgt_x_r};
  assign rdiff_y = {cur_y_r[IW-1], cur_y_r} - {tgt_y_r[IW-1], tgt_y_r};

  // one bresenham step
  assign e2     = {err_r, 1'b0};
  assign ndy    = (EW+1)'(0) - $signed({{(EW+1-DW){1'b0}}, dy_r});
  assign pdx    = $signed({{(EW+1-DW){1'b0}}, dx_r});
  assign move_x = e2 > ndy;
  assign move_y = e2 < pdx;

  always_comb begin
    err_nxt   = err_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (move_x) begin
      cur_x_nxt = neg_x_r ? cur_x_r - IW'(1) : cur_x_r + IW'(1);
    end
    if (move_y) begin
      cur_y_nxt = neg_y_r ? cur_y_r - IW'(1) : cur_y_r + IW'(1);
    end
    err_nxt = err_r - (move_x ? $signed({{(EW-DW){1'b0}}, dy_r}) : EW'(0))
                    + (move_y ? $signed({{(EW-DW){1'b0}}, dx_r}) : EW'(0));
  end

  // brush pixel under the scan counters
  assign px = cur_x_r + {{(IW-OFS_BITS){ofs_i_r[OFS_BITS-1]}}, ofs_i_r};
  assign py = cur_y_r + {{(IW-OFS_BITS){ofs_j_r[OFS_BITS-1]}}, ofs_j_r};
  assign in_frame = !px[IW-1] && ($unsigned(px) < {{(IW-FRAME_BITS){1'b0}}, frame_w_r}) &&
                    !py[IW-1] && ($unsigned(py) < {{(IW-FRAME_BITS){1'b0}}, frame_h_r});
  assign done_w     = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
  assign brush_last = (ofs_i_r == half_s) && (ofs_j_r == half_s);

  assign status.line_active = line_active_r;
  assign status.brush_last  = brush_last;
  assign status.out_free    = !out_valid_r || out_if.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_WIDTH_RST;
      frame_h_r <= FRAME_HEIGHT_RST;
      y_off_r   <= ROW_BIAS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_w_r <= cfg_data[FRAME_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_h_r <= cfg_data[FRAME_BITS-1:0];
        CFG_ROW_BIAS:     y_off_r   <= cfg_data[Y_OFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // line state and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      half_r        <= '0;
      ofs_i_r       <= '0;
      ofs_j_r       <= '0;
    end else begin
      if (cmd.load || cmd.step) begin
        half_r  <= half_nxt;
        ofs_i_r <= neg_half;
        ofs_j_r <= neg_half;
      end else if (cmd.emit && !brush_last) begin
        if (ofs_j_r == half_s) begin
          ofs_j_r <= OFS_BITS'(0) - half_s;
          ofs_i_r <= ofs_i_r + OFS_BITS'(1);
        end else begin
          ofs_j_r <= ofs_j_r + OFS_BITS'(1);
        end
      end
      if (cmd.emit && brush_last) begin
        line_active_r <= !done_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= {{(IW-COORD_BITS){x_start[COORD_BITS-1]}}, x_start};
      cur_y_r <= {{(IW-COORD_BITS){y_start[COORD_BITS-1]}}, y_start} +
                 {{(IW-Y_OFF_BITS){1'b0}}, y_off_r};
      tgt_x_r <= {{(IW-COORD_BITS){x_end[COORD_BITS-1]}}, x_end};
      tgt_y_r <= {{(IW-COORD_BITS){y_end[COORD_BITS-1]}}, y_end} +
                 {{(IW-Y_OFF_BITS){1'b0}}, y_off_r};
      color_r <= line_color;
    end else if (cmd.step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
    if (cmd.calc_d) begin
      // a zero distance counts as a negative step direction
      neg_x_r <= diff_x[IW] || (diff_x == '0);
      neg_y_r <= diff_y[IW] || (diff_y == '0);
      dx_r    <= diff_x[IW] ? rdiff_x[DW-1:0] : diff_x[DW-1:0];
      dy_r    <= diff_y[IW] ? rdiff_y[DW-1:0] : diff_y[DW-1:0];
    end
    if (cmd.calc_e) begin
      err_r <= $signed({{(EW-DW){1'b0}}, dx_r}) - $signed({{(EW-DW){1'b0}}, dy_r});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r     <= px[COORD_BITS:0];
      out_y_r     <= py[COORD_BITS:0];
      out_color_r <= color_r;
      out_we_r    <= in_frame;
      out_last_r  <= brush_last;
      out_done_r  <= brush_last && done_w;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pixel_x      = out_x_r;
  assign out_if.pixel_y      = out_y_r;
  assign out_if.pixel_color  = out_color_r;
  assign out_if.write_enable = out_we_r;
  assign out_if.point_last   = out_last_r;
  assign out_if.line_done    = out_done_r;

  // line completion only ever lands on the closing pixel of a point
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("line_done without point_last");

  a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> line_active_r)
    else $error("bresenham step on an idle line");

  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && brush_last && done_w |=> !line_active_r)
    else $error("line still active after its final point");

  a_setup_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_d |=> cmd.calc_e)
    else $error("error term not formed after distances");

endmodule

`default_nettype wire

@@ verif/thick_line_rasterizer_test.sv @@
// self-checking testbench for thick_line_rasterizer: directed table then random line sequences
// over several frame settings and handshake pacings, checked against a bresenham brush predictor
// depends on tlr_pkg and the tlr_in_if / tlr_out_if channel interfaces
`timescale 1ns / 1ps

module thick_line_rasterizer_test;
  import tlr_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int RANDOM_PHASES   = 5;
  localparam int ADVANCE_CAP     = 40;

  typedef struct {
    logic                     mode;
    logic signed [11:0]       x0, y0, x1, y1;
    logic [2:0]               thick;
    logic [31:0]              color;
  } line_item_t;

  typedef struct {
    logic signed [12:0]       x, y;
    logic [31:0]              color;
    logic                     we, pl, ld;
  } pixel_t;

  typedef struct {
    logic                     mode;
    logic signed [11:0]       x0, y0, x1, y1;
    logic [2:0]               thick;
    logic [31:0]              color;
    logic                     typed;
    logic signed [12:0]       want_x, want_y;
    logic                     want_we, want_pl, want_ld;
  } line_row_t;

  // typed rows are single-pixel brushes whose result is plain from the endpoint
  line_row_t directed_rows [26] = '{
    '{MODE_ADVANCE, -1, -1, -1, -1, 3'd7, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_START, 0, 0, 0, 0, 3'd0, 32'hFFFF_FFFF, 1'b1, 0, 0, 1'b1, 1'b1, 1'b1},
    '{MODE_START, -2048, -2048, -2048, -2048, 3'd1, 32'h0000_0000,
      1'b1, -2048, -2048, 1'b0, 1'b1, 1'b1},
    '{MODE_START, 2047, 2047, 2047, 2047, 3'd0, 32'h1234_5678,
      1'b1, 2047, 2047, 1'b0, 1'b1, 1'b1},
    '{MODE_START, 639, 479, 639, 479, 3'd1, 32'h0000_0001, 1'b1, 639, 479, 1'b1, 1'b1, 1'b1},
    '{MODE_START, 640, 0, 640, 0, 3'd0, 32'h8000_0000, 1'b1, 640, 0, 1'b0, 1'b1, 1'b1},
    '{MODE_START, 0, 480, 0, 480, 3'd0, 32'h7FFF_FFFF, 1'b1, 0, 480, 1'b0, 1'b1, 1'b1},
    '{MODE_START, 0, 0, 3, 1, 3'd7, 32'hA5A5_A5A5, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_START, 10, 10, 5, 20, 3'd2, 32'h5A5A_5A5A, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_START, 1, 1, -4, -6, 3'd3, 32'hC0DE_0001, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_START, -2048, 2047, 2047, -2048, 3'd4, 32'h0F0F_0F0F,
      1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_START, 2, 5, 2, -3, 3'd5, 32'hF0F0_F0F0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_START, -1, -1, 6, -1, 3'd6, 32'h3C3C_3C3C, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_ADVANCE, 0, 0, 0, 0, 3'd0, 32'h0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0}
  };

  int phase_width   [RANDOM_PHASES] = '{1, 2048, 100, 2047, 0};
  int phase_height  [RANDOM_PHASES] = '{1, 2048, 50, 2047, 0};
  int phase_yoff    [RANDOM_PHASES] = '{0, 1023, 5, 512, 0};
  int phase_send_gap[RANDOM_PHASES] = '{0, 83, 0, 13, 0};
  int phase_stall   [RANDOM_PHASES] = '{0, 0, 83, 13, 0};

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_BITS-1:0]    cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;

  tlr_in_if  #(.COORD_BITS(12), .COLOR_BITS(32)) line_ch ();
  tlr_out_if #(.COORD_BITS(12), .COLOR_BITS(32)) pixel_ch ();

  thick_line_rasterizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (line_ch),
    .out_if    (pixel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // brush predictor state
  int          pen_x, pen_y, goal_x, goal_y;
  int          run_x, run_y, slope_err, brush_h;
  bit          x_back, y_back, drawing;
  logic [31:0] pen_color;
  logic [11:0] frame_w, frame_h;
  logic [9:0]  y_off;

  pixel_t      fresh_pixels [$];
  pixel_t      pending_pixels [$];

  int send_gap_pct, stall_pct;
  int errors, cycles;
  int items_taken, drawing_items, phase_items;
  int pixels_seen, pixels_inside, lines_closed, settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // steps the pen for one line item and fills fresh_pixels with the brush around it
  task automatic predict_line(input line_item_t it);
    int     e2, i, j, px, py;
    bit     fin;
    pixel_t p;
    fresh_pixels.delete();
    if (it.mode == MODE_START) begin
      pen_x     = int'(it.x0);
      pen_y     = int'(it.y0) + int'(y_off);
      goal_x    = int'(it.x1);
      goal_y    = int'(it.y1) + int'(y_off);
      run_x     = (goal_x > pen_x) ? goal_x - pen_x : pen_x - goal_x;
      run_y     = (goal_y > pen_y) ? goal_y - pen_y : pen_y - goal_y;
      x_back    = !(pen_x < goal_x);
      y_back    = !(pen_y < goal_y);
      slope_err = run_x - run_y;
      brush_h   = (it.thick > MAX_THICKNESS_DEF ? MAX_THICKNESS_DEF : it.thick) / 2;
      pen_color = it.color;
    end else begin
      if (!drawing) return;
      e2 = 2 * slope_err;
      if (e2 > -run_y) begin
        slope_err -= run_y;
        pen_x += x_back ? -1 : 1;
      end
      if (e2 < run_x) begin
        slope_err += run_x;
        pen_y += y_back ? -1 : 1;
      end
    end
    fin = (pen_x == goal_x) && (pen_y == goal_y);
    drawing = !fin;
    // x offset outer, y offset inner
    for (i = -brush_h; i <= brush_h; i++) begin
      for (j = -brush_h; j <= brush_h; j++) begin
        px      = pen_x + i;
        py      = pen_y + j;
        p.x     = px[12:0];
        p.y     = py[12:0];
        p.color = pen_color;
        p.we    = px >= 0 && px < int'(frame_w) && py >= 0 && py < int'(frame_h);
        p.pl    = (i == brush_h) && (j == brush_h);
        p.ld    = p.pl && fin;
        fresh_pixels.push_back(p);
      end
    end
  endtask

  function automatic void compare_field(input string name, input logic signed [32:0] want,
                                        input logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && pixel_ch.valid && pixel_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel transaction with nothing outstanding at (%0d, %0d)",
               pixel_ch.pixel_x, pixel_ch.pixel_y);
        errors++;
      end else begin
        pixel_t want;
        want = pending_pixels.pop_front();
        compare_field("pixel_x", want.x, pixel_ch.pixel_x);
        compare_field("pixel_y", want.y, pixel_ch.pixel_y);
        compare_field("pixel_color", want.color, pixel_ch.pixel_color);
        compare_field("write_enable", want.we, pixel_ch.write_enable);
        compare_field("point_last", want.pl, pixel_ch.point_last);
        compare_field("line_done", want.ld, pixel_ch.line_done);
        pixels_seen++;
        if (want.we) pixels_inside++;
        if (want.ld) lines_closed++;
      end
    end
    pixel_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_line(input line_item_t it, input bit typed_result);
    if ($urandom_range(99) < send_gap_pct) begin
      line_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    line_ch.valid      <= 1'b1;
    line_ch.mode       <= it.mode;
    line_ch.x_start    <= it.x0;
    line_ch.y_start    <= it.y0;
    line_ch.x_end      <= it.x1;
    line_ch.y_end      <= it.y1;
    line_ch.thickness  <= it.thick;
    line_ch.line_color <= it.color;
    do @(posedge clk); while (line_ch.ready !== 1'b1);
    predict_line(it);
    items_taken++;
    if (fresh_pixels.size() > 0) begin
      drawing_items++;
      phase_items++;
    end
    if (!typed_result)
      foreach (fresh_pixels[k]) pending_pixels.push_back(fresh_pixels[k]);
  endtask

  task automatic drain_results(input int pad);
    line_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  frame_w = val;
      CFG_FRAME_HEIGHT: frame_h = val;
      CFG_ROW_BIAS:     y_off   = val[9:0];
      default: ;
    endcase
  endtask

  // mostly near the origin or a frame edge, now and then anywhere in range
  function automatic logic signed [11:0] pick_coord(input int frame_edge);
    int r, v;
    r = $urandom_range(99);
    if (r < 55)      v = int'($urandom_range(0, 48)) - 8;
    else if (r < 80) v = frame_edge + int'($urandom_range(0, 16)) - 8;
    else             v = $urandom;
    return v[11:0];
  endfunction

  function automatic logic signed [11:0] near_coord(input logic signed [11:0] c);
    int v;
    if ($urandom_range(99) < 80) v = int'(c) + int'($urandom_range(0, 24)) - 12;
    else v = $urandom;
    return v[11:0];
  endfunction

  // one start transaction, then advances until the line closes or is abandoned
  task automatic random_line(input bit pause_here);
    line_item_t it;
    int         steps, k;
    it.mode  = MODE_START;
    it.x0    = pick_coord(int'(frame_w));
    it.y0    = pick_coord(int'(frame_h) - int'(y_off));
    it.x1    = near_coord(it.x0);
    it.y1    = near_coord(it.y0);
    it.thick = 3'($urandom_range(0, 7));
    it.color = $urandom;
    send_line(it, 1'b0);
    if (pause_here) drain_results(0);
    steps = ($urandom_range(99) < 75) ? ADVANCE_CAP : $urandom_range(0, 8);
    for (k = 0; k < steps && drawing; k++) begin
      it.mode  = MODE_ADVANCE;
      it.x0    = 12'($urandom);
      it.y0    = 12'($urandom);
      it.x1    = 12'($urandom);
      it.y1    = 12'($urandom);
      it.thick = 3'($urandom);
      it.color = $urandom;
      send_line(it, 1'b0);
    end
    // stray advance, often with no line left to draw
    if ($urandom_range(99) < 15) begin
      it.mode = MODE_ADVANCE;
      send_line(it, 1'b0);
    end
  endtask

  initial begin : stimulus
    line_item_t it;
    line_row_t  row;
    pixel_t     typed;
    int         r, p, w, h, yo;
    bit         paused;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    line_ch.valid      = 1'b0;
    line_ch.mode       = MODE_START;
    line_ch.x_start    = '0;
    line_ch.y_start    = '0;
    line_ch.x_end      = '0;
    line_ch.y_end      = '0;
    line_ch.thickness  = '0;
    line_ch.line_color = '0;
    pixel_ch.ready     = 1'b0;
    send_gap_pct       = 0;
    stall_pct          = 0;
    errors             = 0;
    cycles             = 0;
    pen_x = 0; pen_y = 0; goal_x = 0; goal_y = 0;
    run_x = 0; run_y = 0; slope_err = 0; brush_h = 0;
    x_back = 0; y_back = 0; drawing = 0;
    pen_color = '0;
    frame_w   = FRAME_WIDTH_RST;
    frame_h   = FRAME_HEIGHT_RST;
    y_off     = ROW_BIAS_RST;
    settings_used = 1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < $size(directed_rows); r++) begin
      row = directed_rows[r];
      it  = '{row.mode, row.x0, row.y0, row.x1, row.y1, row.thick, row.color};
      send_line(it, row.typed);
      if (row.typed) begin
        typed = '{row.want_x, row.want_y, row.color, row.want_we, row.want_pl, row.want_ld};
        pending_pixels.push_back(typed);
      end
    end
    drain_results(SETTLE_CYCLES);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      w  = phase_width[p];
      h  = phase_height[p];
      yo = phase_yoff[p];
      if (p == RANDOM_PHASES - 1) begin
        w  = $urandom_range(1, 2048);
        h  = $urandom_range(1, 2048);
        yo = $urandom_range(0, 1023);
      end
      // 2048 wraps to zero in the 12-bit register, so nothing lands inside the frame
      write_reg(CFG_FRAME_WIDTH, w[11:0]);
      write_reg(CFG_FRAME_HEIGHT, h[11:0]);
      write_reg(CFG_ROW_BIAS, yo[11:0]);
      cfg_we <= 1'b0;
      settings_used++;
      send_gap_pct = phase_send_gap[p];
      stall_pct    = phase_stall[p];
      phase_items  = 0;
      paused       = 1'b0;
      while (phase_items < ITEMS_PER_PHASE) begin
        random_line(!paused && phase_items >= ITEMS_PER_PHASE / 2);
        if (phase_items >= ITEMS_PER_PHASE / 2) paused = 1'b1;
      end
      drain_results(SETTLE_CYCLES);
    end

    $display("covered %0d line transactions (%0d drawing) across %0d frame settings",
             items_taken, drawing_items, settings_used);
    $display("checked %0d pixels, %0d inside the frame, %0d lines run to their end point",
             pixels_seen, pixels_inside, lines_closed);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tlr_pkg.sv
rtl/tlr_channel_if.sv
rtl/tlr_ctrl.sv
rtl/tlr_datapath.sv
rtl/thick_line_rasterizer.sv
verif/thick_line_rasterizer_test.sv
